[hdl/pfsp_pkg.sv]
// Package for the pack format string parser: beat structs, command codes,
// character and kind constants. No dependencies.
`timescale 1ns / 1ps

package pfsp_pkg;

  // Default sizes and limits, handed to the top level as parameters.
  localparam int unsigned MaxIntBytesDef  = 8;
  localparam int unsigned MaxBitCountDef  = 64;
  localparam int unsigned LongBytesDef    = 8;
  localparam int unsigned IntegerBytesDef = 8;
  localparam int unsigned NumberBytesDef  = 8;
  localparam int unsigned SizeBytesDef    = 8;
  localparam int unsigned QueueDepthDef   = 4;

  // Accumulator saturation value.
  localparam logic [11:0] AccMax = 12'hFFF;

  // Result status codes.
  localparam logic [1:0] ST_FIELD   = 2'd0;
  localparam logic [1:0] ST_END     = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_SIZE    = 2'd3;

  // Field kinds.
  localparam logic [2:0] KIND_SINT  = 3'd0;
  localparam logic [2:0] KIND_UINT  = 3'd1;
  localparam logic [2:0] KIND_FLOAT = 3'd2;
  localparam logic [2:0] KIND_RAW   = 3'd3;
  localparam logic [2:0] KIND_SBITS = 3'd4;
  localparam logic [2:0] KIND_UBITS = 3'd5;
  localparam logic [2:0] KIND_BOOL  = 3'd6;

  // Counted option codes.
  localparam logic [2:0] OPT_I_LO = 3'd0;
  localparam logic [2:0] OPT_I_UP = 3'd1;
  localparam logic [2:0] OPT_C    = 3'd2;
  localparam logic [2:0] OPT_R_LO = 3'd3;
  localparam logic [2:0] OPT_R_UP = 3'd4;
  localparam logic [2:0] OPT_V    = 3'd5;

  // Format characters.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  localparam logic [7:0] CH_UP_H  = 8'h48;
  localparam logic [7:0] CH_UP_I  = 8'h49;
  localparam logic [7:0] CH_UP_J  = 8'h4A;
  localparam logic [7:0] CH_UP_L  = 8'h4C;
  localparam logic [7:0] CH_UP_R  = 8'h52;
  localparam logic [7:0] CH_UP_T  = 8'h54;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_LO_C  = 8'h63;
  localparam logic [7:0] CH_LO_D  = 8'h64;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_H  = 8'h68;
  localparam logic [7:0] CH_LO_I  = 8'h69;
  localparam logic [7:0] CH_LO_J  = 8'h6A;
  localparam logic [7:0] CH_LO_L  = 8'h6C;
  localparam logic [7:0] CH_LO_N  = 8'h6E;
  localparam logic [7:0] CH_LO_R  = 8'h72;
  localparam logic [7:0] CH_LO_V  = 8'h76;

  // Command classes passed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_FIXED,
    OP_COUNTED,
    OP_DIGIT,
    OP_SET_LE,
    OP_SET_BE,
    OP_END,
    OP_INVALID
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [2:0]  kind;
    logic [11:0] size_bits;
    logic [2:0]  opt;
    logic [3:0]  dflt;
    logic [3:0]  digit;
  } cmd_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [2:0] bit_offset;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  kind;
    logic [11:0] size_bits;
    logic        little_endian;
    logic        last;
  } result_t;

  // Kind reported for each counted option.
  function automatic logic [2:0] opt_kind(input logic [2:0] opt);
    logic [2:0] k;
    case (opt)
      OPT_I_LO: k = KIND_SINT;
      OPT_I_UP: k = KIND_UINT;
      OPT_C:    k = KIND_RAW;
      OPT_R_LO: k = KIND_SBITS;
      OPT_R_UP: k = KIND_UBITS;
      OPT_V:    k = KIND_BOOL;
      default:  k = KIND_SINT;
    endcase
    return k;
  endfunction

endpackage

[hdl/pfsp_front.sv]
// Front end of the pack format string parser: takes character beats and
// classifies each into a command for the queue. Depends on pfsp_pkg.
`timescale 1ns / 1ps

module pfsp_front import pfsp_pkg::*; #(
  parameter int unsigned LongBytes    = LongBytesDef,
  parameter int unsigned IntegerBytes = IntegerBytesDef,
  parameter int unsigned NumberBytes  = NumberBytesDef,
  parameter int unsigned SizeBytes    = SizeBytesDef
) (
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_data_i,
  output logic  push_o,
  output cmd_t  push_cmd_o,
  input  logic  full_i
);

  localparam logic [11:0] LongBits    = 12'(LongBytes * 8);
  localparam logic [11:0] IntegerBits = 12'(IntegerBytes * 8);
  localparam logic [11:0] NumberBits  = 12'(NumberBytes * 8);
  localparam logic [11:0] SizeBits    = 12'(SizeBytes * 8);

  cmd_t cmd;

  // A beat is taken whenever the queue has room.
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;
  assign push_cmd_o = cmd;

  // Character classification.
  always_comb begin
    cmd       = '0;
    cmd.op    = OP_INVALID;
    cmd.digit = 4'(in_data_i.ch - CH_0);
    case (in_data_i.ch)
      CH_LO_B: begin cmd.op = OP_FIXED; cmd.kind = KIND_SINT;  cmd.size_bits = 12'd8;  end
      CH_UP_B: begin cmd.op = OP_FIXED; cmd.kind = KIND_UINT;  cmd.size_bits = 12'd8;  end
      CH_LO_H: begin cmd.op = OP_FIXED; cmd.kind = KIND_SINT;  cmd.size_bits = 12'd16; end
      CH_UP_H: begin cmd.op = OP_FIXED; cmd.kind = KIND_UINT;  cmd.size_bits = 12'd16; end
      CH_LO_L: begin cmd.op = OP_FIXED; cmd.kind = KIND_SINT;  cmd.size_bits = LongBits; end
      CH_UP_L: begin cmd.op = OP_FIXED; cmd.kind = KIND_UINT;  cmd.size_bits = LongBits; end
      CH_LO_J: begin cmd.op = OP_FIXED; cmd.kind = KIND_SINT;  cmd.size_bits = IntegerBits; end
      CH_UP_J: begin cmd.op = OP_FIXED; cmd.kind = KIND_UINT;  cmd.size_bits = IntegerBits; end
      CH_UP_T: begin cmd.op = OP_FIXED; cmd.kind = KIND_SINT;  cmd.size_bits = SizeBits; end
      CH_LO_F: begin cmd.op = OP_FIXED; cmd.kind = KIND_FLOAT; cmd.size_bits = 12'd32; end
      CH_LO_D: begin cmd.op = OP_FIXED; cmd.kind = KIND_FLOAT; cmd.size_bits = 12'd64; end
      CH_LO_N: begin cmd.op = OP_FIXED; cmd.kind = KIND_FLOAT; cmd.size_bits = NumberBits; end
      CH_LO_I: begin cmd.op = OP_COUNTED; cmd.opt = OPT_I_LO; cmd.dflt = 4'd4; end
      CH_UP_I: begin cmd.op = OP_COUNTED; cmd.opt = OPT_I_UP; cmd.dflt = 4'd4; end
      CH_LO_C: begin cmd.op = OP_COUNTED; cmd.opt = OPT_C;    cmd.dflt = 4'd1; end
      CH_LO_R: begin cmd.op = OP_COUNTED; cmd.opt = OPT_R_LO; cmd.dflt = 4'd1; end
      CH_UP_R: begin cmd.op = OP_COUNTED; cmd.opt = OPT_R_UP; cmd.dflt = 4'd1; end
      CH_LO_V: begin
        cmd.op   = OP_COUNTED;
        cmd.opt  = OPT_V;
        cmd.dflt = {1'b0, in_data_i.bit_offset} + 4'd1;
      end
      CH_LT:   cmd.op = OP_SET_LE;
      CH_GT:   cmd.op = OP_SET_BE;
      CH_NUL:  cmd.op = OP_END;
      default: begin
        if (in_data_i.ch inside {[CH_0:CH_9]}) begin
          cmd.op = OP_DIGIT;
        end
      end
    endcase
  end

endmodule

[hdl/pfsp_queue.sv]
// Short command queue between the front and back ends of the parser.
// Depends on pfsp_pkg for the command struct.
`timescale 1ns / 1ps

module pfsp_queue import pfsp_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  output logic head_valid_o,
  output cmd_t head_cmd_o,
  input  logic pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign full_o       = (cnt_q == DepthCnt);
  assign head_valid_o = (cnt_q != '0);
  assign head_cmd_o   = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

[hdl/pfsp_back.sv]
// Back end of the parser: holds byte order and pending count state, runs
// queued commands and drives the registered result beat. Depends on pfsp_pkg.
`timescale 1ns / 1ps

module pfsp_back import pfsp_pkg::*; #(
  parameter int unsigned MaxIntBytes = MaxIntBytesDef,
  parameter int unsigned MaxBitCount = MaxBitCountDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    head_valid_i,
  input  cmd_t    head_cmd_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  localparam logic [11:0] IntLimit = 12'(MaxIntBytes);
  localparam logic [11:0] BitLimit = 12'(MaxBitCount);

  logic        le_q, le_d;
  logic        pend_q, pend_d;
  logic [2:0]  opt_q, opt_d;
  logic [3:0]  dflt_q, dflt_d;
  logic [11:0] acc_q, acc_d;
  logic        seen_q, seen_d;
  logic        out_valid_q, out_valid_d;
  result_t     out_q, res;

  logic        step;
  logic        emit;
  logic [2:0]  code;
  logic [11:0] cnt, limit;
  logic [15:0] acc_mul;
  logic [11:0] acc_sat;
  result_t     flush;

  assign step        = head_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Count finishing: limit check and size of the pending option.
  always_comb begin
    code = (opt_q > OPT_V) ? OPT_I_LO : opt_q;
    cnt  = seen_q ? acc_q : {8'd0, dflt_q};
    case (code)
      OPT_I_LO, OPT_I_UP: limit = IntLimit;
      OPT_C:              limit = 12'd256;
      OPT_R_LO, OPT_R_UP: limit = BitLimit;
      default:            limit = 12'd8;
    endcase
    flush      = '0;
    flush.kind = opt_kind(code);
    if (cnt == '0 || cnt > limit) begin
      flush.status = ST_SIZE;
    end else begin
      flush.status        = ST_FIELD;
      flush.size_bits     = {cnt[8:0], 3'b000};
      flush.little_endian = (code == OPT_I_LO || code == OPT_I_UP) ? le_q : 1'b0;
    end
  end

  // Decimal accumulate with saturation.
  always_comb begin
    acc_mul = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {12'd0, head_cmd_i.digit};
    acc_sat = (acc_mul > {4'd0, AccMax}) ? AccMax : acc_mul[11:0];
  end

  // Command execution.
  always_comb begin
    le_d   = le_q;
    pend_d = pend_q;
    opt_d  = opt_q;
    dflt_d = dflt_q;
    acc_d  = acc_q;
    seen_d = seen_q;
    res    = '0;
    emit   = 1'b0;
    pop_o  = 1'b0;
    if (step) begin
      if (pend_q) begin
        if (head_cmd_i.op == OP_DIGIT) begin
          acc_d  = acc_sat;
          seen_d = 1'b1;
          pop_o  = 1'b1;
        end else begin
          // Finish the pending option. A byte order modifier or a new counted
          // option gives no beat of its own, so it is taken in the same cycle;
          // any other command stays at the queue head and runs after the flush.
          emit     = 1'b1;
          res      = flush;
          pend_d   = 1'b0;
          opt_d    = '0;
          dflt_d   = '0;
          acc_d    = '0;
          seen_d   = 1'b0;
          res.last = (head_cmd_i.op inside {OP_SET_LE, OP_SET_BE, OP_COUNTED});
          if (res.last) begin
            pop_o = 1'b1;
            case (head_cmd_i.op)
              OP_SET_LE: le_d = 1'b1;
              OP_SET_BE: le_d = 1'b0;
              default: begin
                pend_d = 1'b1;
                opt_d  = head_cmd_i.opt;
                dflt_d = head_cmd_i.dflt;
              end
            endcase
          end
        end
      end else begin
        pop_o    = 1'b1;
        res.last = 1'b1;
        case (head_cmd_i.op)
          OP_FIXED: begin
            emit              = 1'b1;
            res.status        = ST_FIELD;
            res.kind          = head_cmd_i.kind;
            res.size_bits     = head_cmd_i.size_bits;
            res.little_endian = le_q;
          end
          OP_COUNTED: begin
            pend_d = 1'b1;
            opt_d  = head_cmd_i.opt;
            dflt_d = head_cmd_i.dflt;
            acc_d  = '0;
            seen_d = 1'b0;
          end
          OP_SET_LE: le_d = 1'b1;
          OP_SET_BE: le_d = 1'b0;
          OP_END: begin
            emit       = 1'b1;
            res.status = ST_END;
          end
          default: begin
            emit       = 1'b1;
            res.status = ST_INVALID;
          end
        endcase
      end
    end
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      le_q        <= 1'b1;
      pend_q      <= 1'b0;
      opt_q       <= '0;
      dflt_q      <= '0;
      acc_q       <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      le_q        <= le_d;
      pend_q      <= pend_d;
      opt_q       <= opt_d;
      dflt_q      <= dflt_d;
      acc_q       <= acc_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_q <= res;
    end
  end

  // A finished pending option never leaves the pending flag set, unless a new
  // counted option takes its place.
  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && pend_q && head_cmd_i.op != OP_DIGIT && head_cmd_i.op != OP_COUNTED
      |=> !pend_q)
    else $error("pending option not cleared after finishing");

  // A field descriptor always carries a non-zero size.
  a_field_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status == ST_FIELD |-> out_q.size_bits != '0)
    else $error("field descriptor with zero size");

  // End and invalid beats carry no descriptor content.
  a_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status == ST_END || out_q.status == ST_INVALID) |->
      out_q.kind == '0 && out_q.size_bits == '0 && !out_q.little_endian)
    else $error("end or invalid beat carries descriptor content");

  // Raw, bit and boolean fields are never little endian.
  a_no_endian: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind >= KIND_RAW |-> !out_q.little_endian)
    else $error("byte order set on a field without byte order");

endmodule

[hdl/pack_format_string_parser_unit.sv]
// Character beats pass through the command queue; result beats are registered.
// Throughput: one character per cycle while the queue has room; a character that
// finishes a pending counted option and gives its own result waits at the queue
// head during the flush, as the single result register takes one beat per cycle.
// Reset: asynchronous; byte order little endian, no option pending, queue empty.
`timescale 1ns / 1ps

module pack_format_string_parser_unit import pfsp_pkg::*; #(
  parameter int unsigned MaxIntBytes  = MaxIntBytesDef,
  parameter int unsigned MaxBitCount  = MaxBitCountDef,
  parameter int unsigned LongBytes    = LongBytesDef,
  parameter int unsigned IntegerBytes = IntegerBytesDef,
  parameter int unsigned NumberBytes  = NumberBytesDef,
  parameter int unsigned SizeBytes    = SizeBytesDef,
  parameter int unsigned QueueDepth   = QueueDepthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  item_t   in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  logic push, full, head_valid, pop;
  cmd_t push_cmd, head_cmd;

  // Character classification.
  pfsp_front #(
    .LongBytes    (LongBytes),
    .IntegerBytes (IntegerBytes),
    .NumberBytes  (NumberBytes),
    .SizeBytes    (SizeBytes)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .full_i     (full)
  );

  // Decoupling queue.
  pfsp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd),
    .pop_i        (pop)
  );

  // Execution and result register.
  pfsp_back #(
    .MaxIntBytes (MaxIntBytes),
    .MaxBitCount (MaxBitCount)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_cmd_i   (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule
